[hdl/swtm_pkg.sv]
package swtm_pkg;

   // Window geometry.
   localparam int WINDOW   = 4;
   localparam int CHANNELS = 4;
   localparam int DEPTH    = CHANNELS * WINDOW;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int ADDR_W   = $clog2(DEPTH);

   // Field widths.
   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 2;
   localparam int PASS_W   = 4;

   // Accumulator and divider widths. The largest sum magnitude is WINDOW * 2^15.
   localparam int SUM_W  = SAMPLE_W + 1 + $clog2(WINDOW);
   localparam int MAG_W  = SUM_W - 1;
   localparam int SHIFT  = MAG_W + 4;
   localparam int MUL_W  = SHIFT + 1;
   localparam int PROD_W = MAG_W + MUL_W;

   // Reciprocals for division by a constant: ceil(2^SHIFT / d), exact for MAG_W-bit dividends.
   localparam logic [MUL_W-1:0] RECIP_PUSH =
      MUL_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam logic [MUL_W-1:0] RECIP_TRIM =
      MUL_W'(((64'd1 << SHIFT) + 64'(WINDOW - 2) - 64'd1) / 64'(WINDOW - 2));

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FILTER_PASSES = 1'b0;
   localparam logic [PASS_W-1:0] PASS_RESET = 4'd4;

   // Request modes.
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_TRIM = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_LAST,
      ST_PUSH_NEW,
      ST_TRIM_RD,
      ST_TRIM_LAST,
      ST_TRIM_DIV,
      ST_DIV_WAIT,
      ST_TRIM_WLO,
      ST_TRIM_WHI,
      ST_DONE
   } state_type;

   // Write port of the window memory.
   typedef struct packed {
      logic                       en;
      logic [ADDR_W-1:0]          addr;
      logic signed [SAMPLE_W-1:0] data;
   } wr_type;

   // Memory address of one slot of one channel's window.
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [CHAN_W-1:0] ch,
                                                    input logic [SLOT_W-1:0] slot);
      slot_addr = ADDR_W'(int'(ch) * WINDOW + int'(slot));
   endfunction

endpackage

[hdl/sample_window_trimmed_mean.sv]
// Push word: busy until the result strobe, which comes in the last busy cycle.
// Filter word: busy through all passes, then the result strobe; each pass reads the window once
// through the single memory read port, then the divider and two write-backs follow.
// Zero passes or channel out of range: result 0, memory untouched. One word at a time.
// Reset clears the window valid bits at once (all samples read 0) and sets passes to 4.
module sample_window_trimmed_mean (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_mode,
   input  logic [swtm_pkg::CHAN_W-1:0]           req_channel,
   input  logic signed [swtm_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                  rsp_valid,
   output logic signed [swtm_pkg::SAMPLE_W-1:0]  rsp_value,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [swtm_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [swtm_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [swtm_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   swtm_pkg::state_type                   state_ff, state_in;
   logic [swtm_pkg::SLOT_W-1:0]           cnt_ff, cnt_in;
   logic [swtm_pkg::PASS_W-1:0]           pass_ff, pass_in;
   logic [swtm_pkg::PASS_W-1:0]           passes_ff;
   logic                                  mode_ff;
   logic [swtm_pkg::CHAN_W-1:0]           chan_ff;
   logic signed [swtm_pkg::SAMPLE_W-1:0]  sample_ff;
   logic signed [swtm_pkg::SUM_W-1:0]     acc_ff, acc_in;
   logic signed [swtm_pkg::SAMPLE_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [swtm_pkg::SLOT_W-1:0]           lo_at_ff, lo_at_in, hi_at_ff, hi_at_in;
   logic signed [swtm_pkg::SAMPLE_W-1:0]  res_ff, res_in;
   logic                                  rvalid_ff;
   logic [swtm_pkg::SLOT_W-1:0]           rslot_ff;

   logic                                  accept;
   logic                                  chan_ok;
   logic                                  csr_wr;
   logic                                  rd_en;
   logic [swtm_pkg::ADDR_W-1:0]           rd_addr;
   logic signed [swtm_pkg::SAMPLE_W-1:0]  rd_data;
   swtm_pkg::wr_type                      wr;
   logic                                  div_start;
   logic signed [swtm_pkg::SUM_W-1:0]     div_numer;
   logic                                  div_valid;
   logic signed [swtm_pkg::SAMPLE_W-1:0]  div_quot;

   assign accept  = start && !busy;
   assign chan_ok = int'(req_channel) < swtm_pkg::CHANNELS;

   // Configuration register access.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         passes_ff <= swtm_pkg::PASS_RESET;
      end else if (csr_wr && csr_paddr[2] == swtm_pkg::REG_FILTER_PASSES) begin
         passes_ff <= csr_pwdata[swtm_pkg::PASS_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == swtm_pkg::REG_FILTER_PASSES) ?
                       swtm_pkg::CSR_DATA_W'(passes_ff) : '0;

   // Window memory and constant divider.
   swtm_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   swtm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_start),
      .in_trim   (mode_ff),
      .in_numer  (div_numer),
      .out_valid (div_valid),
      .out_quot  (div_quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swtm_pkg::ST_IDLE: begin
            if (accept) begin
               if (!chan_ok) begin
                  state_in = swtm_pkg::ST_DONE;
               end else if (req_mode == swtm_pkg::MODE_PUSH) begin
                  state_in = swtm_pkg::ST_PUSH_RD;
               end else if (passes_ff == '0) begin
                  state_in = swtm_pkg::ST_DONE;
               end else begin
                  state_in = swtm_pkg::ST_TRIM_RD;
               end
            end
         end
         swtm_pkg::ST_PUSH_RD: begin
            if (cnt_ff == '0) begin
               state_in = swtm_pkg::ST_PUSH_LAST;
            end
         end
         swtm_pkg::ST_PUSH_LAST: state_in = swtm_pkg::ST_PUSH_NEW;
         swtm_pkg::ST_PUSH_NEW:  state_in = swtm_pkg::ST_DIV_WAIT;
         swtm_pkg::ST_TRIM_RD: begin
            if (cnt_ff == swtm_pkg::SLOT_W'(swtm_pkg::WINDOW - 1)) begin
               state_in = swtm_pkg::ST_TRIM_LAST;
            end
         end
         swtm_pkg::ST_TRIM_LAST: state_in = swtm_pkg::ST_TRIM_DIV;
         swtm_pkg::ST_TRIM_DIV:  state_in = swtm_pkg::ST_DIV_WAIT;
         swtm_pkg::ST_DIV_WAIT: begin
            if (div_valid) begin
               state_in = (mode_ff == swtm_pkg::MODE_TRIM) ? swtm_pkg::ST_TRIM_WLO
                                                           : swtm_pkg::ST_DONE;
            end
         end
         swtm_pkg::ST_TRIM_WLO: state_in = swtm_pkg::ST_TRIM_WHI;
         swtm_pkg::ST_TRIM_WHI: begin
            state_in = (pass_ff == passes_ff - 1'b1) ? swtm_pkg::ST_DONE
                                                     : swtm_pkg::ST_TRIM_RD;
         end
         swtm_pkg::ST_DONE: state_in = swtm_pkg::ST_IDLE;
         default:           state_in = swtm_pkg::ST_IDLE;
      endcase
   end

   // Outputs: memory ports, divider start and the result strobe.
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = swtm_pkg::slot_addr(chan_ff, cnt_ff);
      wr.en     = 1'b0;
      wr.addr   = swtm_pkg::slot_addr(chan_ff, swtm_pkg::SLOT_W'(rslot_ff + 1'b1));
      wr.data   = rd_data;
      div_start = 1'b0;
      div_numer = acc_ff;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         swtm_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         swtm_pkg::ST_PUSH_RD, swtm_pkg::ST_TRIM_RD: begin
            rd_en = 1'b1;
         end
         swtm_pkg::ST_PUSH_NEW: begin
            wr.en     = 1'b1;
            wr.addr   = swtm_pkg::slot_addr(chan_ff, '0);
            wr.data   = sample_ff;
            div_start = 1'b1;
         end
         swtm_pkg::ST_TRIM_DIV: begin
            div_start = 1'b1;
            div_numer = acc_ff - swtm_pkg::SUM_W'(lo_ff) - swtm_pkg::SUM_W'(hi_ff);
         end
         swtm_pkg::ST_TRIM_WLO: begin
            wr.en   = 1'b1;
            wr.addr = swtm_pkg::slot_addr(chan_ff, lo_at_ff);
            wr.data = res_ff;
         end
         swtm_pkg::ST_TRIM_WHI: begin
            wr.en   = 1'b1;
            wr.addr = swtm_pkg::slot_addr(chan_ff, hi_at_ff);
            wr.data = res_ff;
         end
         swtm_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
      // A word read in push mode moves one slot toward the old end.
      if (rvalid_ff && mode_ff == swtm_pkg::MODE_PUSH) begin
         wr.en = 1'b1;
      end
   end

   assign rsp_value = res_ff;

   // Datapath: sum, first minimum and first maximum, counters and result.
   always_comb begin
      cnt_in   = cnt_ff;
      pass_in  = pass_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      lo_at_in = lo_at_ff;
      hi_at_in = hi_at_ff;
      res_in   = res_ff;

      if (rvalid_ff) begin
         acc_in = acc_ff + swtm_pkg::SUM_W'(rd_data);
         if (rslot_ff == '0) begin
            lo_in    = rd_data;
            hi_in    = rd_data;
            lo_at_in = '0;
            hi_at_in = '0;
         end else begin
            if (rd_data < lo_ff) begin
               lo_in    = rd_data;
               lo_at_in = rslot_ff;
            end
            if (rd_data > hi_ff) begin
               hi_in    = rd_data;
               hi_at_in = rslot_ff;
            end
         end
      end

      case (state_ff)
         swtm_pkg::ST_IDLE: begin
            if (accept) begin
               pass_in = '0;
               res_in  = '0;
               if (req_mode == swtm_pkg::MODE_PUSH) begin
                  cnt_in = swtm_pkg::SLOT_W'(swtm_pkg::WINDOW - 2);
                  acc_in = swtm_pkg::SUM_W'(req_sample);
               end else begin
                  cnt_in = '0;
                  acc_in = '0;
               end
            end
         end
         swtm_pkg::ST_PUSH_RD: cnt_in = cnt_ff - 1'b1;
         swtm_pkg::ST_TRIM_RD: cnt_in = cnt_ff + 1'b1;
         swtm_pkg::ST_DIV_WAIT: begin
            if (div_valid) begin
               res_in = div_quot;
            end
         end
         swtm_pkg::ST_TRIM_WHI: begin
            pass_in = pass_ff + 1'b1;
            cnt_in  = '0;
            acc_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= swtm_pkg::ST_IDLE;
         rvalid_ff <= 1'b0;
         cnt_ff    <= '0;
         pass_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rd_en;
         cnt_ff    <= cnt_in;
         pass_ff   <= pass_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         chan_ff   <= req_channel;
         sample_ff <= req_sample;
      end
      rslot_ff <= cnt_ff;
      acc_ff   <= acc_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      lo_at_ff <= lo_at_in;
      hi_at_ff <= hi_at_in;
      res_ff   <= res_in;
   end

endmodule

[hdl/swtm_ram.sv]
module swtm_ram (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         rd_en,
   input  logic [swtm_pkg::ADDR_W-1:0]                  rd_addr,
   input  swtm_pkg::wr_type                             wr,
   output logic signed [swtm_pkg::SAMPLE_W-1:0]         rd_data
);

   logic signed [swtm_pkg::SAMPLE_W-1:0] mem_ff [swtm_pkg::DEPTH];
   logic [swtm_pkg::DEPTH-1:0]           valid_ff;
   logic signed [swtm_pkg::SAMPLE_W-1:0] rdata_ff;
   logic                                 rvalid_ff;

   // Sample storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff  <= mem_ff[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

[hdl/swtm_div.sv]
module swtm_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic                                  in_trim,
   input  logic signed [swtm_pkg::SUM_W-1:0]     in_numer,
   output logic                                  out_valid,
   output logic signed [swtm_pkg::SAMPLE_W-1:0]  out_quot
);

   logic                                 v1_ff, v2_ff;
   logic                                 neg1_ff, neg2_ff;
   logic                                 trim1_ff;
   logic [swtm_pkg::MAG_W-1:0]           mag1_ff;
   logic [swtm_pkg::PROD_W-1:0]          prod_ff;
   logic [swtm_pkg::PROD_W-1:0]          prod_in;
   logic signed [swtm_pkg::SUM_W-1:0]    abs_val;
   logic [swtm_pkg::MUL_W-1:0]           recip;
   logic [swtm_pkg::SAMPLE_W:0]          q_mag;
   logic [swtm_pkg::SAMPLE_W:0]          q_fix;

   // Stage one splits the dividend into sign and magnitude.
   assign abs_val = in_numer[swtm_pkg::SUM_W-1] ? -in_numer : in_numer;

   // Stage two multiplies the magnitude by the reciprocal of the divisor.
   assign recip   = trim1_ff ? swtm_pkg::RECIP_TRIM : swtm_pkg::RECIP_PUSH;
   assign prod_in = swtm_pkg::PROD_W'(mag1_ff) * swtm_pkg::PROD_W'(recip);

   always_ff @(posedge clock) begin
      mag1_ff  <= abs_val[swtm_pkg::MAG_W-1:0];
      neg1_ff  <= in_numer[swtm_pkg::SUM_W-1];
      trim1_ff <= in_trim;
      prod_ff  <= prod_in;
      neg2_ff  <= neg1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // The quotient is the product shifted down; the sign goes back on, truncating toward zero.
   assign q_mag     = prod_ff[swtm_pkg::SHIFT +: (swtm_pkg::SAMPLE_W + 1)];
   assign q_fix     = neg2_ff ? (~q_mag + 1'b1) : q_mag;
   assign out_quot  = q_fix[swtm_pkg::SAMPLE_W-1:0];
   assign out_valid = v2_ff;

endmodule

[sim/tb_sample_window_trimmed_mean.sv]
module tb_sample_window_trimmed_mean;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_WORDS = 150;
   localparam int REG_UNUSED  = 1;

   // Tracks each channel window and the pass count, and holds the values that are still due.
   class trimmed_mean_board;
      logic signed [swtm_pkg::SAMPLE_W-1:0] win [swtm_pkg::CHANNELS][swtm_pkg::WINDOW];
      logic [swtm_pkg::PASS_W-1:0]          passes;
      logic signed [swtm_pkg::SAMPLE_W-1:0] due_values [$];
      int                                   mismatches;
      int                                   checked;

      function new();
         foreach (win[c, k]) win[c][k] = '0;
         passes     = swtm_pkg::PASS_RESET;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void flag(string what, int want, int got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] mismatch on %s: expected %0d, actual %0d", $realtime, what, want, got);
         end
      endfunction

      function void set_reg(int reg_index, logic [swtm_pkg::CSR_DATA_W-1:0] data);
         if (reg_index == int'(swtm_pkg::REG_FILTER_PASSES)) begin
            passes = data[swtm_pkg::PASS_W-1:0];
         end
      endfunction

      function void check_reg(logic [swtm_pkg::CSR_DATA_W-1:0] got);
         if (got !== swtm_pkg::CSR_DATA_W'(passes)) begin
            flag("filter_passes readback", int'(passes), int'(got));
         end
      endfunction

      // Works out the value an accepted word will return and updates the window.
      function void note_word(logic mode, logic [swtm_pkg::CHAN_W-1:0] ch,
                              logic signed [swtm_pkg::SAMPLE_W-1:0] sample);
         int sum;
         int lo;
         int hi;
         int lo_at;
         int hi_at;
         int q;
         q = 0;
         if (int'(ch) < swtm_pkg::CHANNELS) begin
            if (mode == swtm_pkg::MODE_PUSH) begin
               sum = sample;
               for (int k = swtm_pkg::WINDOW - 1; k > 0; k--) begin
                  win[ch][k] = win[ch][k-1];
                  sum += win[ch][k];
               end
               win[ch][0] = sample;
               q = sum / swtm_pkg::WINDOW;
            end else begin
               for (int p = 0; p < int'(passes); p++) begin
                  lo    = win[ch][0];
                  hi    = win[ch][0];
                  lo_at = 0;
                  hi_at = 0;
                  sum   = 0;
                  for (int k = 0; k < swtm_pkg::WINDOW; k++) begin
                     if (win[ch][k] < lo) begin
                        lo    = win[ch][k];
                        lo_at = k;
                     end
                     if (win[ch][k] > hi) begin
                        hi    = win[ch][k];
                        hi_at = k;
                     end
                     sum += win[ch][k];
                  end
                  q = (sum - hi - lo) / (swtm_pkg::WINDOW - 2);
                  // The minimum slot is written first, then the maximum slot.
                  win[ch][lo_at] = swtm_pkg::SAMPLE_W'(q);
                  win[ch][hi_at] = swtm_pkg::SAMPLE_W'(q);
               end
            end
         end
         due_values.push_back(swtm_pkg::SAMPLE_W'(q));
      endfunction

      function void check_value(logic signed [swtm_pkg::SAMPLE_W-1:0] got);
         logic signed [swtm_pkg::SAMPLE_W-1:0] want;
         if (due_values.size() == 0) begin
            flag("unexpected result value", 0, int'(got));
         end else begin
            want = due_values.pop_front();
            checked++;
            if (got !== want) begin
               flag("result value", int'(want), int'(got));
            end
         end
      endfunction

      function int pending();
         return due_values.size();
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic                                 req_mode = swtm_pkg::MODE_PUSH;
   logic [swtm_pkg::CHAN_W-1:0]          req_channel = '0;
   logic signed [swtm_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                 rsp_valid;
   logic signed [swtm_pkg::SAMPLE_W-1:0] rsp_value;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [swtm_pkg::CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [swtm_pkg::CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [swtm_pkg::CSR_DATA_W-1:0]      csr_prdata;
   logic                                 csr_pready;

   trimmed_mean_board                    sb = new();
   int                                   cycle_count = 0;
   int                                   push_words = 0;
   int                                   filter_words = 0;
   int                                   reg_writes = 0;
   logic signed [swtm_pkg::SAMPLE_W-1:0] last_sample = '0;

   sample_window_trimmed_mean dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_mode    (req_mode),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_value   (rsp_value),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sb.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Observe results, accepted words and register accesses on each rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            sb.check_value(rsp_value);
         end
         if (start && !busy) begin
            sb.note_word(req_mode, req_channel, req_sample);
            if (req_mode == swtm_pkg::MODE_PUSH) push_words++;
            else filter_words++;
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               sb.set_reg(int'(csr_paddr) / 4, csr_pwdata);
               reg_writes++;
            end else if (csr_paddr == '0) begin
               sb.check_reg(csr_prdata);
            end
         end
      end
   end

   // Present one word and return at the edge where it is accepted.
   task automatic send_word(input logic m, input logic [swtm_pkg::CHAN_W-1:0] c,
                            input logic signed [swtm_pkg::SAMPLE_W-1:0] s);
      start       <= 1'b1;
      req_mode    <= m;
      req_channel <= c;
      req_sample  <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Wait until every due result has come back and the block is idle.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0 || busy);
      repeat (3) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, access cycle, then the bus goes idle.
   task automatic csr_access(input logic wr, input int reg_index,
                             input logic [swtm_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= swtm_pkg::CSR_ADDR_W'(reg_index * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Change the pass count while idle, with random upper bits, and read it back.
   task automatic set_passes(input int value);
      drain();
      csr_access(1'b1, int'(swtm_pkg::REG_FILTER_PASSES),
                 {(swtm_pkg::CSR_DATA_W - swtm_pkg::PASS_W)'($urandom),
                  swtm_pkg::PASS_W'(value)});
      csr_access(1'b0, int'(swtm_pkg::REG_FILTER_PASSES), '0);
   endtask

   // Samples lean toward the extremes, small values and repeats so that ties are frequent.
   function automatic logic signed [swtm_pkg::SAMPLE_W-1:0] next_sample();
      case ($urandom_range(0, 9))
         0: last_sample = 16'sh7FFF;
         1: last_sample = 16'sh8000;
         2: last_sample = swtm_pkg::SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
         3: last_sample = last_sample;
         default: last_sample = swtm_pkg::SAMPLE_W'($urandom);
      endcase
      return last_sample;
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   initial begin
      int plan [9];
      int pv;
      bit quiet;
      logic m;

      plan = '{15, 0, 1, 4, -1, -1, 15, 2, -1};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of the pass count, then a filter on an empty window.
      csr_access(1'b0, int'(swtm_pkg::REG_FILTER_PASSES), '0);
      send_word(swtm_pkg::MODE_TRIM, 2'd0, 16'sh1234);

      // Fill windows with the positive and negative extremes and filter them.
      repeat (4) send_word(swtm_pkg::MODE_PUSH, 2'd0, 16'sh7FFF);
      send_word(swtm_pkg::MODE_TRIM, 2'd0, '0);
      repeat (4) send_word(swtm_pkg::MODE_PUSH, 2'd1, 16'sh8000);
      send_word(swtm_pkg::MODE_TRIM, 2'd1, '0);

      // Mixed signs, where the mean must truncate toward zero.
      send_word(swtm_pkg::MODE_PUSH, 2'd2, 16'sh7FFF);
      send_word(swtm_pkg::MODE_PUSH, 2'd2, 16'sh8000);
      send_word(swtm_pkg::MODE_PUSH, 2'd2, 16'sd5);
      send_word(swtm_pkg::MODE_PUSH, 2'd2, -16'sd3);
      send_word(swtm_pkg::MODE_TRIM, 2'd2, '0);
      send_word(swtm_pkg::MODE_PUSH, 2'd3, -16'sd1);
      send_word(swtm_pkg::MODE_PUSH, 2'd3, -16'sd2);
      send_word(swtm_pkg::MODE_PUSH, 2'd3, 16'sd1);
      send_word(swtm_pkg::MODE_PUSH, 2'd3, -16'sd1);
      send_word(swtm_pkg::MODE_TRIM, 2'd3, 16'shFFFF);

      // With zero passes the filter returns 0 and leaves the window alone.
      set_passes(0);
      send_word(swtm_pkg::MODE_TRIM, 2'd2, '0);
      send_word(swtm_pkg::MODE_PUSH, 2'd2, 16'sd100);

      // A write to an unused register must not disturb the pass count.
      drain();
      csr_access(1'b1, REG_UNUSED, 32'hFFFF_FFFF);
      csr_access(1'b0, int'(swtm_pkg::REG_FILTER_PASSES), '0);

      set_passes(15);
      send_word(swtm_pkg::MODE_TRIM, 2'd2, '0);
      set_passes(1);
      send_word(swtm_pkg::MODE_TRIM, 2'd3, '0);

      // Random phases, each under its own pass count.
      foreach (plan[ph]) begin
         pv = (plan[ph] < 0) ? $urandom_range(0, 15) : plan[ph];
         set_passes(pv);
         quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            m = ($urandom_range(0, 3) == 0) ? swtm_pkg::MODE_TRIM : swtm_pkg::MODE_PUSH;
            send_word(m, swtm_pkg::CHAN_W'($urandom), next_sample());
            if (!quiet) pause(gap_len());
         end
      end

      drain();
      repeat (20) @(posedge clock);

      $display("Checked %0d results: %0d sample pushes and %0d filter runs on %0d channels",
               sb.checked, push_words, filter_words, swtm_pkg::CHANNELS);
      $display("%0d register writes with pass counts from 0 to 15; %0d mismatches",
               reg_writes, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/swtm_pkg.sv
hdl/swtm_ram.sv
hdl/swtm_div.sv
hdl/sample_window_trimmed_mean.sv
sim/tb_sample_window_trimmed_mean.sv
